>>> rtl/sat_pkg.sv
`default_nettype none

package sat_pkg;

   // item field widths
   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // configuration port
   localparam int CAP_W      = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_RESET  = 256;

   // register index, taken from paddr bit 2 (word address)
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   // operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // control sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_INSERT,
      S_REMOVE,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/sat_if.sv
`default_nettype none

// request channel
interface sat_req_if;
   logic                         valid;
   logic                         ready;
   logic [sat_pkg::MODE_W-1:0]   mode;
   logic [sat_pkg::VALUE_W-1:0]  value;
   logic [sat_pkg::INDEX_W-1:0]  index;

   modport source (output valid, output mode, output value, output index, input ready);
   modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

// response channel
interface sat_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sat_pkg::VALUE_W-1:0]   read_value;
   logic [sat_pkg::STATUS_W-1:0]  status;
   logic [sat_pkg::COUNT_W-1:0]   count;

   modport source (output valid, output read_value, output status, output count, input ready);
   modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/sat_ram.sv
`default_nettype none

module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/sorted_array_table_core.sv
`default_nettype none

// channel   direction  handshake       payload
// req_if    in         valid / ready   mode, value, index
// rsp_if    out        valid / ready   read_value, status, count
// apb csr   in         psel / penable  capacity at byte address 0
//
// one item at a time; a lookup reads the ram through S_LOOKUP, rejected or no-op items go straight to S_RESULT
// insert shifts larger entries up from the top, remove shifts the entries above the index down,
// with one entry read and one entry write per cycle through the single ram
// reset clears the count and the sequencer; ram contents are never cleared
// a new item is taken while the previous result sits in the output register

module sorted_array_table_core #(
   parameter int DEPTH       = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sat_req_if.sink                               req_if,
   sat_rsp_if.source                             rsp_if,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [sat_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [sat_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sat_pkg::state_type              state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [sat_pkg::CAP_W-1:0]       cap_ff, cap_in;
   logic [AW-1:0]                   pos_ff, pos_in;
   logic                            bottom_ff, bottom_in;
   logic [VALUE_WIDTH-1:0]          value_ff, value_in;
   logic [sat_pkg::VALUE_W-1:0]     res_data_ff, res_data_in;
   sat_pkg::status_type             res_status_ff, res_status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sat_pkg::VALUE_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [sat_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [sat_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [VALUE_WIDTH-1:0]          ram_wdata;
   logic [AW-1:0]                   ram_raddr;
   logic [VALUE_WIDTH-1:0]          ram_rdata;

   logic                            req_accept;
   logic                            table_full;
   logic                            in_range;
   logic                            last_entry;
   logic                            can_load;
   logic                            csr_write;
   logic [AW-1:0]                   idx_addr;

   // entry store
   sat_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[sat_pkg::CSR_ADDR_W-1] == sat_pkg::CSR_IDX_CAPACITY);
   assign cap_in    = csr_write ? pwdata[sat_pkg::CAP_W-1:0] : cap_ff;
   assign prdata    = (paddr[sat_pkg::CSR_ADDR_W-1] == sat_pkg::CSR_IDX_CAPACITY)
                      ? sat_pkg::CSR_DATA_W'(cap_ff) : '0;

   // request decode
   assign req_accept = req_if.valid && req_if.ready;
   assign table_full = (32'(count_ff) >= 32'(cap_ff)) || (32'(count_ff) >= DEPTH);
   assign in_range   = 32'(req_if.index) < 32'(count_ff);
   assign last_entry = (32'(req_if.index) + 32'd1) == 32'(count_ff);
   assign idx_addr   = AW'(req_if.index);
   assign can_load   = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == sat_pkg::S_IDLE);

   // sequencer: next state, ram access and result capture
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      bottom_in     = bottom_ff;
      value_in      = value_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = '0;

      unique case (state_ff)
         sat_pkg::S_IDLE: begin
            if (req_accept) begin
               value_in      = VALUE_WIDTH'(req_if.value);
               res_data_in   = '0;
               res_status_in = sat_pkg::STAT_DONE;
               state_in      = sat_pkg::S_RESULT;
               priority if (req_if.mode == sat_pkg::MODE_INSERT) begin
                  if (table_full) begin
                     res_status_in = sat_pkg::STAT_FULL;
                  end else begin
                     // scan down from the top entry, shifting as we go
                     pos_in    = AW'(count_ff);
                     bottom_in = (count_ff == '0);
                     ram_raddr = AW'(count_ff - CW'(1));
                     state_in  = sat_pkg::S_INSERT;
                  end
               end else if (req_if.mode == sat_pkg::MODE_LOOKUP) begin
                  if (in_range) begin
                     ram_raddr = idx_addr;
                     state_in  = sat_pkg::S_LOOKUP;
                  end else begin
                     res_status_in = sat_pkg::STAT_RANGE;
                  end
               end else if (req_if.mode == sat_pkg::MODE_REMOVE) begin
                  if (!in_range) begin
                     res_status_in = sat_pkg::STAT_RANGE;
                  end else if (last_entry) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     pos_in    = idx_addr;
                     ram_raddr = idx_addr + AW'(1);
                     state_in  = sat_pkg::S_REMOVE;
                  end
               end else begin
                  // unused mode: no change
                  res_status_in = sat_pkg::STAT_DONE;
               end
            end
         end

         sat_pkg::S_LOOKUP: begin
            res_data_in = sat_pkg::VALUE_W'(ram_rdata);
            state_in    = sat_pkg::S_RESULT;
         end

         sat_pkg::S_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            if (bottom_ff || (ram_rdata < value_ff)) begin
               // entry below is smaller: new value lands here
               ram_wdata = value_ff;
               count_in  = count_ff + CW'(1);
               state_in  = sat_pkg::S_RESULT;
            end else begin
               // move entry up one place, read the next one down
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - AW'(1);
               bottom_in = (pos_ff == AW'(1));
               ram_raddr = pos_ff - AW'(2);
            end
         end

         sat_pkg::S_REMOVE: begin
            // move entry down one place
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = ram_rdata;
            if ((CW'(pos_ff) + CW'(2)) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = sat_pkg::S_RESULT;
            end else begin
               pos_in    = pos_ff + AW'(1);
               ram_raddr = pos_ff + AW'(2);
            end
         end

         sat_pkg::S_RESULT: begin
            if (can_load) begin
               state_in = sat_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sat_pkg::S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == sat_pkg::S_RESULT) && can_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = sat_pkg::COUNT_W'(count_ff);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = rsp_data_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.count      = rsp_count_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sat_pkg::S_IDLE;
         count_ff     <= '0;
         cap_ff       <= sat_pkg::CAP_W'(sat_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      bottom_ff     <= bottom_in;
      value_ff      <= value_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int TABLE_DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int END_SETTLE_CYCLES = 20;

   // mode 3 has no operation code in the package; it is a no-op
   localparam logic [sat_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
   localparam logic [sat_pkg::CSR_ADDR_W-1:0] CAPACITY_ADDR =
      {sat_pkg::CSR_IDX_CAPACITY, 2'b00};

   typedef struct {
      logic [sat_pkg::VALUE_W-1:0] read_value;
      sat_pkg::status_type         status;
      logic [sat_pkg::COUNT_W-1:0] count;
   } table_result_type;

   // shadow of the sorted table plus the queue of results still owed
   class sorted_table_tracker;
      logic [sat_pkg::VALUE_W-1:0] slots [TABLE_DEPTH];
      int                 fill;
      int                 cap_reg;
      table_result_type   awaited [$];
      int errors, checked, cap_writes, peak_fill;
      int n_insert, n_full, n_lookup, n_remove, n_range, n_nop;

      function new();
         fill = 0;
         cap_reg = sat_pkg::CAP_RESET;
         errors = 0; checked = 0; cap_writes = 0; peak_fill = 0;
         n_insert = 0; n_full = 0; n_lookup = 0; n_remove = 0; n_range = 0; n_nop = 0;
      endfunction

      function void set_capacity(logic [sat_pkg::CSR_DATA_W-1:0] data);
         cap_reg = int'(data[sat_pkg::CAP_W-1:0]);
         cap_writes++;
      endfunction

      // apply one accepted item to the shadow table and queue its result
      function void apply_request(logic [sat_pkg::MODE_W-1:0] mode,
                                  logic [sat_pkg::VALUE_W-1:0] value,
                                  logic [sat_pkg::INDEX_W-1:0] index);
         table_result_type res;
         int limit;
         int pos;
         int k;
         res.read_value = '0;
         res.status = sat_pkg::STAT_DONE;
         limit = (cap_reg < TABLE_DEPTH) ? cap_reg : TABLE_DEPTH;
         case (mode)
            sat_pkg::MODE_INSERT: begin
               n_insert++;
               if (fill >= limit) begin
                  res.status = sat_pkg::STAT_FULL;
                  n_full++;
               end else begin
                  // first slot not less than value; equal values go in front
                  pos = 0;
                  while (pos < fill && slots[pos] < value) pos++;
                  for (k = fill; k > pos; k--) slots[k] = slots[k-1];
                  slots[pos] = value;
                  fill++;
               end
            end
            sat_pkg::MODE_LOOKUP: begin
               n_lookup++;
               if (int'(index) < fill) begin
                  res.read_value = slots[index];
               end else begin
                  res.status = sat_pkg::STAT_RANGE;
                  n_range++;
               end
            end
            sat_pkg::MODE_REMOVE: begin
               n_remove++;
               if (int'(index) < fill) begin
                  for (k = int'(index); k + 1 < fill; k++) slots[k] = slots[k+1];
                  fill--;
               end else begin
                  res.status = sat_pkg::STAT_RANGE;
                  n_range++;
               end
            end
            default: begin
               n_nop++;
            end
         endcase
         if (fill > peak_fill) peak_fill = fill;
         res.count = sat_pkg::COUNT_W'(fill);
         awaited.push_back(res);
      endfunction

      // compare one accepted result with the oldest owed result
      function void check_response(logic [sat_pkg::VALUE_W-1:0] read_value,
                                   logic [sat_pkg::STATUS_W-1:0] status,
                                   logic [sat_pkg::COUNT_W-1:0] count);
         table_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with none outstanding: read_value %h status %0d count %0d",
                        $time, read_value, status, count);
         end else begin
            want = awaited.pop_front();
            checked++;
            if (read_value !== want.read_value || status !== want.status ||
                count !== want.count) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: mismatch read_value %h/%h status %0d/%0d count %0d/%0d %s",
                           $time, want.read_value, read_value, want.status, status,
                           want.count, count, "(expected/actual)");
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [sat_pkg::CSR_ADDR_W-1:0] paddr;
   logic [sat_pkg::CSR_DATA_W-1:0] pwdata;
   logic [sat_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;
   logic steady_flow;
   logic hold_request;
   int   quiet_cycles;
   sorted_table_tracker tracker;

   sat_req_if req_bus();
   sat_rsp_if rsp_bus();

   sorted_array_table_core #(
      .DEPTH       (TABLE_DEPTH),
      .VALUE_WIDTH (sat_pkg::VALUE_W)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // small values give duplicates, a few extremes, the rest anywhere
   function automatic logic [sat_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom_range(0, 15);
      if (r == 3) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // offer one item after a random gap; returns at the falling edge after acceptance
   task automatic send_item(input logic [sat_pkg::MODE_W-1:0] mode,
                            input logic [sat_pkg::VALUE_W-1:0] value,
                            input logic [sat_pkg::INDEX_W-1:0] index);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.mode  = mode;
      req_bus.value = value;
      req_bus.index = index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.apply_request(mode, value, index);
      @(negedge clock);
   endtask

   // stop offering and wait for every owed result
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (tracker.awaited.size() != 0) @(negedge clock);
   endtask

   // apb write of the capacity register, only with the table idle
   task automatic write_capacity(input logic [sat_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CAPACITY_ADDR;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.set_capacity(data);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // random mix of operations, indexes mostly inside the table
   task automatic random_run(input int n, input int ins_pct, input int rem_pct);
      int r;
      int i;
      logic [sat_pkg::MODE_W-1:0] mode;
      logic [sat_pkg::INDEX_W-1:0] index;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) mode = sat_pkg::MODE_INSERT;
         else if (r < ins_pct + rem_pct) mode = sat_pkg::MODE_REMOVE;
         else if (r < 97) mode = sat_pkg::MODE_LOOKUP;
         else mode = MODE_NOP;
         if (tracker.fill > 0 && $urandom_range(0, 4) != 0)
            index = sat_pkg::INDEX_W'($urandom_range(0, tracker.fill - 1));
         else
            index = sat_pkg::INDEX_W'($urandom_range(0, 255));
         send_item(mode, pick_value(), index);
      end
   endtask

   // result side: random stalls plus one long hold when asked
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady_flow && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_response(rsp_bus.read_value, rsp_bus.status, rsp_bus.count);
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // main sequence
   initial begin
      tracker = new();
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      steady_flow = 1'b0;
      hold_request = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.mode = sat_pkg::MODE_INSERT;
      req_bus.value = '0;
      req_bus.index = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table at reset capacity
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd0);
      send_item(sat_pkg::MODE_REMOVE, '1, 8'd0);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd255);
      send_item(MODE_NOP, '1, 8'hFF);

      // extremes and duplicates, equal values land in front
      send_item(sat_pkg::MODE_INSERT, 32'hFFFF_FFFF, 8'hFF);
      send_item(sat_pkg::MODE_INSERT, 32'h0000_0000, 8'h00);
      send_item(sat_pkg::MODE_INSERT, 32'h8000_0000, 8'h55);
      send_item(sat_pkg::MODE_INSERT, 32'h8000_0000, 8'hAA);
      send_item(sat_pkg::MODE_INSERT, 32'h0000_0000, 8'h00);
      send_item(sat_pkg::MODE_INSERT, 32'h7FFF_FFFF, 8'h00);
      for (int i = 0; i < 7; i++)
         send_item(sat_pkg::MODE_LOOKUP, $urandom, i[sat_pkg::INDEX_W-1:0]);

      // remove last, first, middle, then past the end
      send_item(sat_pkg::MODE_REMOVE, '0, 8'd5);
      send_item(sat_pkg::MODE_REMOVE, '0, 8'd0);
      send_item(sat_pkg::MODE_REMOVE, '0, 8'd1);
      send_item(sat_pkg::MODE_REMOVE, '0, 8'd3);
      send_item(MODE_NOP, '0, 8'd0);

      // capacity one, set below the current count
      write_capacity(32'd1);
      send_item(sat_pkg::MODE_INSERT, 32'h1234_5678, 8'd0);
      repeat (3) send_item(sat_pkg::MODE_REMOVE, '0, 8'd0);
      send_item(sat_pkg::MODE_INSERT, 32'hDEAD_BEEF, 8'd0);
      send_item(sat_pkg::MODE_INSERT, 32'h0000_0001, 8'd0);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd0);

      // capacity zero rejects every insert
      write_capacity(32'd0);
      send_item(sat_pkg::MODE_INSERT, 32'h0000_0005, 8'd0);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd0);
      send_item(sat_pkg::MODE_REMOVE, '0, 8'd0);
      send_item(sat_pkg::MODE_INSERT, 32'h0000_0006, 8'd0);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd0);

      // small tables, one phase without gaps, one with a long result hold
      for (int p = 0; p < 6; p++) begin
         write_capacity($urandom_range(2, 24));
         steady_flow = (p == 1);
         if (p == 3) hold_request = 1'b1;
         random_run(30, 50, 30);
      end
      steady_flow = 1'b0;

      // capacity above depth saturates; fill the whole table
      write_capacity(32'hFFFF_FFFF);
      while (tracker.fill < TABLE_DEPTH)
         send_item(sat_pkg::MODE_INSERT, pick_value(), sat_pkg::INDEX_W'($urandom));
      send_item(sat_pkg::MODE_INSERT, pick_value(), 8'd0);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd255);
      send_item(sat_pkg::MODE_LOOKUP, '0, 8'd0);
      random_run(30, 40, 30);
      write_capacity(sat_pkg::CSR_DATA_W'(TABLE_DEPTH));
      random_run(30, 45, 25);

      // drain and settle
      wait_idle();
      repeat (END_SETTLE_CYCLES) @(negedge clock);
      if (tracker.awaited.size() != 0) begin
         tracker.errors++;
         $display("%0d results never arrived", tracker.awaited.size());
      end

      $display("covered %0d inserts (%0d refused full), %0d lookups, %0d removes,",
               tracker.n_insert, tracker.n_full, tracker.n_lookup, tracker.n_remove);
      $display("%0d out of range, %0d no-ops, %0d results checked, table peak %0d of %0d,",
               tracker.n_range, tracker.n_nop, tracker.checked, tracker.peak_fill,
               TABLE_DEPTH);
      $display("%0d capacity writes, %0d errors", tracker.cap_writes, tracker.errors);
      if (tracker.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
